// ===== src/mlr_pkg.sv =====
// ----------------------------------------------------------------------------
// mlr_pkg: shared types and constants of the midpoint line rasterizer
// Holds the coordinate widths, the segment descriptor passed from the front
// end to the stepper, and the stepper state type.
// ----------------------------------------------------------------------------
`default_nettype none

package mlr_pkg;

   // Width of one grid coordinate.
   localparam int COORD_BITS = 6;

   // The decision value stays within +/- 2 * (2^COORD_BITS - 1), which needs
   // two more bits than a coordinate, including the sign.
   localparam int DEC_BITS = COORD_BITS + 2;

   // Descriptor queue between the front end and the stepper.
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   typedef logic [COORD_BITS-1:0]      coord_type;
   typedef logic signed [DEC_BITS-1:0] dec_type;

   // One classified segment, ready for the stepper.
   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type major_len;  // number of steps along the major axis
      logic      y_major;    // y is the major axis
      logic      x_neg;      // x moves toward smaller values
      logic      y_neg;      // y moves toward smaller values
      dec_type   dec_init;   // 2*minor - major
      dec_type   inc_keep;   // 2*minor
      dec_type   inc_step;   // 2*(minor - major)
   } seg_desc_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_RUN
   } back_state_type;

endpackage : mlr_pkg

`default_nettype wire

// ===== src/mlr_front.sv =====
// ----------------------------------------------------------------------------
// mlr_front: segment classifier
// Takes one segment, finds the deltas, step directions and major axis, and
// builds the descriptor with the initial decision value and its increments.
// ----------------------------------------------------------------------------
`default_nettype none

module mlr_front (
   input  wire  mlr_pkg::coord_type    start_x,
   input  wire  mlr_pkg::coord_type    start_y,
   input  wire  mlr_pkg::coord_type    end_x,
   input  wire  mlr_pkg::coord_type    end_y,
   output mlr_pkg::seg_desc_type       desc
);
   import mlr_pkg::*;

   logic      x_neg;
   logic      y_neg;
   coord_type dx;
   coord_type dy;
   logic      y_major;
   coord_type major_len;
   coord_type minor_len;
   dec_type   major_x2;
   dec_type   minor_x2;

   // Absolute deltas and step directions.
   always_comb begin
      x_neg = (end_x < start_x);
      y_neg = (end_y < start_y);
      dx    = x_neg ? (start_x - end_x) : (end_x - start_x);
      dy    = y_neg ? (start_y - end_y) : (end_y - start_y);
   end

   // Major axis choice: x wins a tie.
   always_comb begin
      y_major   = (dx < dy);
      major_len = y_major ? dy : dx;
      minor_len = y_major ? dx : dy;
      major_x2  = dec_type'({1'b0, major_len, 1'b0});
      minor_x2  = dec_type'({1'b0, minor_len, 1'b0});
   end

   // Descriptor for the stepper.
   always_comb begin
      desc.start_x   = start_x;
      desc.start_y   = start_y;
      desc.major_len = major_len;
      desc.y_major   = y_major;
      desc.x_neg     = x_neg;
      desc.y_neg     = y_neg;
      desc.dec_init  = minor_x2 - dec_type'({2'b00, major_len});
      desc.inc_keep  = minor_x2;
      desc.inc_step  = minor_x2 - major_x2;
   end

endmodule : mlr_front

`default_nettype wire

// ===== src/mlr_queue.sv =====
// ----------------------------------------------------------------------------
// mlr_queue: short descriptor queue
// A small flip-flop FIFO that decouples the classifier from the stepper.
// ----------------------------------------------------------------------------
`default_nettype none

module mlr_queue (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          push,
   input  wire  mlr_pkg::seg_desc_type  push_desc,
   output logic                         full,
   input  wire                          pop,
   output mlr_pkg::seg_desc_type        pop_desc,
   output logic                         empty
);
   import mlr_pkg::*;

   seg_desc_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0]   count_ff;
   logic [QUEUE_CNT_BITS-1:0]   count_in;
   logic                        do_push;
   logic                        do_pop;

   // Status and handshake qualification.
   always_comb begin
      full    = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
      empty   = (count_ff == '0);
      do_push = push && !full;
      do_pop  = pop && !empty;
   end

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   assign pop_desc = entry_ff[rd_ptr_ff];

endmodule : mlr_queue

`default_nettype wire

// ===== src/mlr_back.sv =====
// ----------------------------------------------------------------------------
// mlr_back: pixel stepper
// Loads one descriptor, then walks the major axis one pixel per cycle, into an
// output register while it is free or drained, stepping the minor axis by the midpoint decision.
// ----------------------------------------------------------------------------
`default_nettype none

module mlr_back (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          desc_valid,
   input  wire  mlr_pkg::seg_desc_type  desc,
   output logic                         desc_pop,
   output logic                         rsp_empty,
   input  wire                          rsp_pop,
   output mlr_pkg::coord_type           rsp_pixel_x,
   output mlr_pkg::coord_type           rsp_pixel_y,
   output logic                         rsp_last_pixel
);
   import mlr_pkg::*;

   back_state_type state_ff;
   back_state_type state_in;
   coord_type      x_ff;
   coord_type      x_in;
   coord_type      y_ff;
   coord_type      y_in;
   coord_type      remain_ff;
   coord_type      remain_in;
   dec_type        dec_ff;
   dec_type        dec_in;
   dec_type        inc_keep_ff;
   dec_type        inc_keep_in;
   dec_type        inc_step_ff;
   dec_type        inc_step_in;
   logic           y_major_ff;
   logic           y_major_in;
   logic           x_neg_ff;
   logic           x_neg_in;
   logic           y_neg_ff;
   logic           y_neg_in;
   logic           out_valid_ff;
   logic           out_valid_in;
   coord_type      out_x_ff;
   coord_type      out_x_in;
   coord_type      out_y_ff;
   coord_type      out_y_in;
   logic           out_last_ff;
   logic           out_last_in;
   logic           emit;
   logic           minor_step;
   logic           move_x;
   logic           move_y;
   coord_type      x_next;
   coord_type      y_next;

   // A pixel is produced when the output register is free or being drained.
   always_comb begin
      emit       = (state_ff == BACK_RUN) && (!out_valid_ff || rsp_pop);
      minor_step = !(dec_ff[DEC_BITS-1] || (dec_ff == '0));
      move_x     = y_major_ff ? minor_step : 1'b1;
      move_y     = y_major_ff ? 1'b1 : minor_step;
      x_next     = x_neg_ff ? (x_ff - 1'b1) : (x_ff + 1'b1);
      y_next     = y_neg_ff ? (y_ff - 1'b1) : (y_ff + 1'b1);
   end

   // Next state and datapath updates.
   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      remain_in    = remain_ff;
      dec_in       = dec_ff;
      inc_keep_in  = inc_keep_ff;
      inc_step_in  = inc_step_ff;
      y_major_in   = y_major_ff;
      x_neg_in     = x_neg_ff;
      y_neg_in     = y_neg_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_last_in  = out_last_ff;
      desc_pop     = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            if (desc_valid) begin
               desc_pop    = 1'b1;
               x_in        = desc.start_x;
               y_in        = desc.start_y;
               remain_in   = desc.major_len;
               dec_in      = desc.dec_init;
               inc_keep_in = desc.inc_keep;
               inc_step_in = desc.inc_step;
               y_major_in  = desc.y_major;
               x_neg_in    = desc.x_neg;
               y_neg_in    = desc.y_neg;
               state_in    = BACK_RUN;
            end
         end
         BACK_RUN: begin
            if (emit) begin
               out_valid_in = 1'b1;
               out_x_in     = x_ff;
               out_y_in     = y_ff;
               out_last_in  = (remain_ff == '0);
               if (remain_ff == '0) begin
                  state_in = BACK_IDLE;
               end else begin
                  remain_in = remain_ff - 1'b1;
                  dec_in    = dec_ff + (minor_step ? inc_step_ff : inc_keep_ff);
                  if (move_x) begin
                     x_in = x_next;
                  end
                  if (move_y) begin
                     y_in = y_next;
                  end
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      remain_ff   <= remain_in;
      dec_ff      <= dec_in;
      inc_keep_ff <= inc_keep_in;
      inc_step_ff <= inc_step_in;
      y_major_ff  <= y_major_in;
      x_neg_ff    <= x_neg_in;
      y_neg_ff    <= y_neg_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_pixel_x    = out_x_ff;
   assign rsp_pixel_y    = out_y_ff;
   assign rsp_last_pixel = out_last_ff;

   // The final pixel of a segment returns the stepper to idle.
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (emit && (remain_ff == '0)) |=> (state_ff == BACK_IDLE))
      else $error("stepper did not return to idle after the final pixel");

   // Each non-final pixel consumes exactly one major step.
   a_remain_counts: assert property (@(posedge clock) disable iff (reset)
      (emit && (remain_ff != '0)) |=> (remain_ff == $past(remain_ff) - 1'b1))
      else $error("step counter did not decrement on a pixel");

   // A result only appears while a segment is being walked.
   a_emit_from_run: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == BACK_RUN))
      else $error("result appeared without an active segment");

   // A descriptor is taken only when the stepper is idle.
   a_load_when_idle: assert property (@(posedge clock) disable iff (reset)
      desc_pop |-> ((state_ff == BACK_IDLE) && desc_valid))
      else $error("descriptor taken while the stepper was busy");

endmodule : mlr_back

`default_nettype wire

// ===== src/midpoint_line_rasterizer_unit.sv =====
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_unit: midpoint line rasterizer top level
// Turns one segment into the run of grid pixels from its start to its end.
// ----------------------------------------------------------------------------
// Usage:
//   Segments enter through a queue-style port: a transaction happens on a
//   clock edge with req_push high and req_full low. Pixels leave through a
//   queue-style port: while rsp_empty is low the oldest pixel is on the rsp_
//   ports, and a transaction happens on an edge with rsp_pop high.
//   A segment whose larger delta is N yields N + 1 pixels; the last one is
//   the end point and carries rsp_last_pixel. A single point yields one pixel.
//   A segment passes through the descriptor queue entry and the stepper's
//   registers before its first pixel reaches the output register.
//   Throughput: the stepper loads a segment while idle and then walks one
//   pixel per cycle while the output register is free or being drained.
//   The stepper sets this rate; the classifier and a two-entry descriptor
//   queue take further segments meanwhile.
//   Reset empties the descriptor queue and the output register and idles
//   the stepper. When the receiver stalls, the pixel on the rsp_ ports holds
//   and the stepper waits; once the queue fills, req_full rises.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_line_rasterizer_unit (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_push,
   output logic                       req_full,
   input  wire  mlr_pkg::coord_type   req_start_x,
   input  wire  mlr_pkg::coord_type   req_start_y,
   input  wire  mlr_pkg::coord_type   req_end_x,
   input  wire  mlr_pkg::coord_type   req_end_y,
   output logic                       rsp_empty,
   input  wire                        rsp_pop,
   output mlr_pkg::coord_type         rsp_pixel_x,
   output mlr_pkg::coord_type         rsp_pixel_y,
   output logic                       rsp_last_pixel
);
   import mlr_pkg::*;

   seg_desc_type front_desc;
   seg_desc_type queue_desc;
   logic         queue_empty;
   logic         queue_pop;

   // Classify the incoming segment.
   mlr_front u_front (
      .start_x (req_start_x),
      .start_y (req_start_y),
      .end_x   (req_end_x),
      .end_y   (req_end_y),
      .desc    (front_desc)
   );

   // Hold classified segments until the stepper is free.
   mlr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_desc (front_desc),
      .full      (req_full),
      .pop       (queue_pop),
      .pop_desc  (queue_desc),
      .empty     (queue_empty)
   );

   // Walk each segment into pixels.
   mlr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .desc_valid     (!queue_empty),
      .desc           (queue_desc),
      .desc_pop       (queue_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_last_pixel (rsp_last_pixel)
   );

endmodule : midpoint_line_rasterizer_unit

`default_nettype wire
